FILE: design/swsd_pkg.sv
// ----------------------------------------------------------------------------
// swsd_pkg
// Shared types and constants of the sliding window stability detector.
// ----------------------------------------------------------------------------
`default_nettype none

package swsd_pkg;

    localparam int WLEN_W    = 7;
    localparam int DELTA_W   = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_DELTA = 1'b1;

    localparam logic [WLEN_W-1:0]  WINDOW_LEN_RST   = 7'd8;
    localparam logic [DELTA_W-1:0] STABLE_DELTA_RST = 32'd10;
    localparam logic [WLEN_W-1:0]  WINDOW_LEN_MIN   = 7'd2;

    typedef struct packed {
        logic init;
        logic upd;
    } swsd_mm_ctrl_t;

endpackage

`default_nettype wire

FILE: design/swsd_minmax.sv
// ----------------------------------------------------------------------------
// swsd_minmax
// Running minimum and maximum over the window scan, with range and
// threshold compare.
// ----------------------------------------------------------------------------
`default_nettype none

module swsd_minmax
    import swsd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 32
) (
    input  wire logic                    aclk,
    input  wire swsd_mm_ctrl_t           ctrl,
    input  wire logic [SAMPLE_WIDTH-1:0] init_val,
    input  wire logic [SAMPLE_WIDTH-1:0] din,
    input  wire logic [DELTA_W-1:0]      delta,
    output logic      [SAMPLE_WIDTH-1:0] range,
    output logic                         below
);

    localparam int CMP_W = (SAMPLE_WIDTH > DELTA_W) ? SAMPLE_WIDTH : DELTA_W;

    logic [SAMPLE_WIDTH-1:0] lo_reg, lo_next;
    logic [SAMPLE_WIDTH-1:0] hi_reg, hi_next;

    always_comb begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (ctrl.init) begin
            lo_next = init_val;
            hi_next = init_val;
        end else if (ctrl.upd) begin
            if (din < lo_reg) lo_next = din;
            if (din > hi_reg) hi_next = din;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    // offset-binary samples, so the unsigned difference is the signed range
    assign range = hi_reg - lo_reg;
    assign below = CMP_W'(range) < CMP_W'(delta);

endmodule

`default_nettype wire

FILE: design/sliding_window_stability_detector.sv
// ----------------------------------------------------------------------------
// sliding_window_stability_detector
// Keeps the most recent valid samples in a ring memory and reports the
// window range and a stability flag for every request.
// ----------------------------------------------------------------------------
// sequence: a valid sample that leaves two or more samples held runs the ring
//   scan (scan and last states) before the done state; other requests go
//   straight to done; requests are taken one at a time, only in the idle state,
//   and the ring scan reads one sample per cycle
// reset: pointers, fill count, handshake and config registers cleared to
//   their reset values; ring contents are left as they are
`default_nettype none

module sliding_window_stability_detector
    import swsd_pkg::*;
#(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // request channel
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_tdata,  // sample
    input  wire logic                                  s_tuser,  // sample_valid
    // result channel
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic      [((SAMPLE_WIDTH+7)/8)*8-1:0]     m_tdata,  // window_range
    output logic                                       m_tuser,  // stable flag
    // config write port
    input  wire logic                                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]                  cfg_index,
    input  wire logic [CFG_W-1:0]                      cfg_wdata
);

    localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int AW     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);

    localparam logic [AW-1:0]    PTR_LAST  = AW'(WINDOW_MAX - 1);
    localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(WINDOW_MAX);
    localparam logic [SAMPLE_WIDTH-1:0] SIGN_BIT = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_LAST = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [WLEN_W-1:0]  window_len_reg;
    logic [DELTA_W-1:0] stable_delta_reg;

    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_count_reg, fill_count_next;
    logic [CNT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic             zero_res_reg, zero_res_next;
    logic             rd_vld_reg;

    logic                    m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_WIDTH-1:0] m_range_reg, m_range_next;
    logic                    m_stable_reg, m_stable_next;

    logic [SAMPLE_WIDTH-1:0] ring_mem [WINDOW_MAX];
    logic [SAMPLE_WIDTH-1:0] rd_data_reg;

    logic                    s_accept;
    logic                    wr_en;
    logic [SAMPLE_WIDTH-1:0] sample_ob;
    logic [CNT_W-1:0]        eff_len;
    logic [CNT_W:0]          fill_inc;
    logic [CNT_W-1:0]        fill_new;
    logic                    out_free;

    swsd_mm_ctrl_t           mm_ctrl;
    logic [SAMPLE_WIDTH-1:0] mm_range;
    logic                    mm_below;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign wr_en     = s_accept && s_tuser;
    assign sample_ob = s_tdata[SAMPLE_WIDTH-1:0] ^ SIGN_BIT;
    assign out_free  = !m_tvalid_reg || m_tready;

    // window length clamped to the legal span
    always_comb begin
        if (window_len_reg < WINDOW_LEN_MIN) begin
            eff_len = CNT_TWO;
        end else if (32'(window_len_reg) > 32'(WINDOW_MAX)) begin
            eff_len = CNT_MAX;
        end else begin
            eff_len = CNT_W'(window_len_reg);
        end
    end

    assign fill_inc = {1'b0, fill_count_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign fill_new = (fill_inc > {1'b0, eff_len}) ? eff_len : fill_inc[CNT_W-1:0];

    always_comb begin
        state_next      = state_reg;
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        fill_count_next = fill_count_reg;
        scan_cnt_next   = scan_cnt_reg;
        zero_res_next   = zero_res_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_range_next    = m_range_reg;
        m_stable_next   = m_stable_reg;
        mm_ctrl.init    = 1'b0;
        mm_ctrl.upd     = rd_vld_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser) begin
                        mm_ctrl.init    = 1'b1;
                        wr_ptr_next     = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
                        rd_ptr_next     = (wr_ptr_reg == '0) ? PTR_LAST : wr_ptr_reg - 1'b1;
                        fill_count_next = fill_new;
                        scan_cnt_next   = fill_new - CNT_ONE;
                        if (fill_new < CNT_TWO) begin
                            zero_res_next = 1'b1;
                            state_next    = ST_DONE;
                        end else begin
                            zero_res_next = 1'b0;
                            state_next    = ST_SCAN;
                        end
                    end else begin
                        zero_res_next = 1'b1;
                        state_next    = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                rd_ptr_next   = (rd_ptr_reg == '0) ? PTR_LAST : rd_ptr_reg - 1'b1;
                scan_cnt_next = scan_cnt_reg - CNT_ONE;
                if (scan_cnt_reg == CNT_ONE) state_next = ST_LAST;
            end
            ST_LAST: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_range_next  = zero_res_reg ? '0 : mm_range;
                    m_stable_next = !zero_res_reg && mm_below;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            fill_count_reg   <= '0;
            scan_cnt_reg     <= '0;
            zero_res_reg     <= 1'b0;
            rd_vld_reg       <= 1'b0;
            m_tvalid_reg     <= 1'b0;
            window_len_reg   <= WINDOW_LEN_RST;
            stable_delta_reg <= STABLE_DELTA_RST;
        end else begin
            state_reg      <= state_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            fill_count_reg <= fill_count_next;
            scan_cnt_reg   <= scan_cnt_next;
            zero_res_reg   <= zero_res_next;
            rd_vld_reg     <= (state_reg == ST_SCAN);
            m_tvalid_reg   <= m_tvalid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_WINDOW_LEN:   window_len_reg   <= cfg_wdata[WLEN_W-1:0];
                    CFG_STABLE_DELTA: stable_delta_reg <= cfg_wdata[DELTA_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_range_reg  <= m_range_next;
        m_stable_reg <= m_stable_next;
    end

    // sample ring
    always_ff @(posedge aclk) begin
        if (wr_en) ring_mem[wr_ptr_reg] <= sample_ob;
        rd_data_reg <= ring_mem[rd_ptr_reg];
    end

    swsd_minmax #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_minmax (
        .aclk     (aclk),
        .ctrl     (mm_ctrl),
        .init_val (sample_ob),
        .din      (rd_data_reg),
        .delta    (stable_delta_reg),
        .range    (mm_range),
        .below    (mm_below)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = DATA_W'(m_range_reg);
    assign m_tuser  = m_stable_reg;

    a_out_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result appeared outside the done state");

    a_scan_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (scan_cnt_reg != '0))
        else $error("scan running with no reads left");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= CNT_MAX)
        else $error("fill count beyond ring depth");

    a_fill_after_write: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> (fill_count_reg != '0))
        else $error("fill count empty after a stored sample");

endmodule

`default_nettype wire

FILE: tb/swsd_result_checker.sv
// ----------------------------------------------------------------------------
// swsd_result_checker
// Watches the request, result and config ports of the stability detector.
// Keeps its own window of samples and config copy, predicts the range and
// stable flag of every accepted request, and compares each result in order.
// ----------------------------------------------------------------------------
module swsd_result_checker
    import swsd_pkg::*;
#(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,  // sample
    input  wire logic                              s_tuser,  // sample_valid
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata,  // window_range
    input  wire logic                              m_tuser,  // stable flag
    input  wire logic                              cfg_we,
    input  wire logic [CFG_IDX_W-1:0]              cfg_index,
    input  wire logic [CFG_W-1:0]                  cfg_wdata,
    output int                                     mismatch_count,
    output int                                     pending,
    output int                                     results_seen,
    output int                                     stable_seen
);

    typedef struct packed {
        logic                    stable;
        logic [SAMPLE_WIDTH-1:0] spread;
    } window_result_t;

    logic signed [SAMPLE_WIDTH-1:0] ring [WINDOW_MAX];
    int                             wr_ptr;
    int                             fill;
    logic [WLEN_W-1:0]              win_len;
    logic [DELTA_W-1:0]             delta;
    window_result_t                 expected_results [$];

    function automatic window_result_t predict_window(input logic [SAMPLE_WIDTH-1:0] smp,
                                                      input logic vld);
        window_result_t                 res;
        logic signed [SAMPLE_WIDTH-1:0] lo;
        logic signed [SAMPLE_WIDTH-1:0] hi;
        logic signed [SAMPLE_WIDTH-1:0] cur;
        int                             len;
        int                             idx;
        int                             k;
        res = '0;
        if (!vld)
            return res;
        ring[wr_ptr] = smp;
        wr_ptr = (wr_ptr + 1) % WINDOW_MAX;
        len = int'(win_len);
        if (len < 2)
            len = 2;
        if (len > WINDOW_MAX)
            len = WINDOW_MAX;
        fill = (fill + 1 > len) ? len : fill + 1;
        if (fill < 2)
            return res;
        lo = smp;
        hi = smp;
        for (k = 0; k < fill; k++) begin
            idx = (wr_ptr + WINDOW_MAX - 1 - k) % WINDOW_MAX;
            cur = ring[idx];
            if (cur < lo)
                lo = cur;
            if (cur > hi)
                hi = cur;
        end
        res.spread = hi - lo;
        res.stable = (res.spread < delta);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input window_result_t want,
                                   input window_result_t got);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("mismatch at %0t: %s: expected stable=%0b range=%0d, %s%0b range=%0d",
                     $realtime, what, want.stable, want.spread, "got stable=",
                     got.stable, got.spread);
    endtask

    always @(posedge aclk) begin
        window_result_t got;
        window_result_t want;
        if (!aresetn) begin
            wr_ptr  = 0;
            fill    = 0;
            win_len = WINDOW_LEN_RST;
            delta   = STABLE_DELTA_RST;
            expected_results.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_WINDOW_LEN)
                    win_len = cfg_wdata[WLEN_W-1:0];
                else if (cfg_index == CFG_STABLE_DELTA)
                    delta = cfg_wdata[DELTA_W-1:0];
            end
            if (m_tvalid && m_tready) begin
                got.stable = m_tuser;
                got.spread = m_tdata[SAMPLE_WIDTH-1:0];
                results_seen++;
                if (m_tuser)
                    stable_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no request outstanding", '0, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.stable !== want.stable)
                        report_mismatch("stable flag", want, got);
                    if (got.spread !== want.spread)
                        report_mismatch("window_range", want, got);
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_window(s_tdata[SAMPLE_WIDTH-1:0], s_tuser));
        end
        pending = expected_results.size();
    end

endmodule

FILE: tb/sliding_window_stability_detector_tb.sv
// ----------------------------------------------------------------------------
// sliding_window_stability_detector_tb
// Drives directed and random sample requests through the stability detector
// under several window and delta settings and idle patterns, with long
// result stalls and drain pauses; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module sliding_window_stability_detector_tb;
    import swsd_pkg::*;

    localparam int WINDOW_MAX    = 64;
    localparam int SAMPLE_WIDTH  = 32;
    localparam int DW            = ((SAMPLE_WIDTH+7)/8)*8;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = WINDOW_MAX + 8;
    localparam int LONG_HOLD     = 400;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [DW-1:0]        s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [DW-1:0]        m_tdata;
    logic                 m_tuser;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    int mismatch_count;
    int pending;
    int results_seen;
    int stable_seen;
    int req_count;
    int invalid_count;
    int reg_writes;
    int cycle_count;
    int send_idle_pct;
    int stall_pct;
    int hold_trigger;
    int hold_taken;
    int hold_left;

    logic [SAMPLE_WIDTH-1:0] walk_base = '0;

    sliding_window_stability_detector #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    swsd_result_checker #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .mismatch_count(mismatch_count),
        .pending       (pending),
        .results_seen  (results_seen),
        .stable_seen   (stable_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side backpressure
    always @(posedge aclk) begin
        if (hold_taken != hold_trigger) begin
            hold_taken = hold_trigger;
            hold_left  = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic push_req(input logic [SAMPLE_WIDTH-1:0] smp, input logic vld);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= vld;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        req_count++;
        if (!vld)
            invalid_count++;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 20)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            s_tuser  <= 1'($urandom_range(1));
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        wait_drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cfg_wdata <= $urandom;
        reg_writes++;
    endtask

    task automatic set_window(input logic [WLEN_W-1:0] len);
        logic [CFG_W-1:0] val;
        val = $urandom;
        val[WLEN_W-1:0] = len;
        write_reg(CFG_WINDOW_LEN, val);
    endtask

    function automatic logic [SAMPLE_WIDTH-1:0] next_sample(input int unsigned spread);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return walk_base + $urandom_range(spread) - spread / 2;
        if (pick < 78)
            return $urandom;
        if (pick < 88) begin
            case ($urandom_range(3))
                0: return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
                1: return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
                2: return '0;
                default: return '1;
            endcase
        end
        walk_base = $urandom;
        return walk_base;
    endfunction

    task automatic run_phase(input logic [WLEN_W-1:0] len, input logic [DELTA_W-1:0] dlt,
                             input int unsigned spread, input int spct, input int rpct,
                             input int n, input bit long_hold);
        int i;
        set_window(len);
        write_reg(CFG_STABLE_DELTA, dlt);
        send_idle_pct = spct;
        stall_pct     = rpct;
        walk_base     = $urandom;
        for (i = 0; i < n; i++) begin
            if (long_hold && i == n / 3)
                hold_trigger++;
            if (i == n / 2)
                wait_drain();
            push_req(next_sample(spread), $urandom_range(99) < 85);
        end
    endtask

    initial begin
        logic [DELTA_W-1:0] rnd_delta;
        int                 k;
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed: invalid on empty window, single sample, full-scale range
        push_req(32'hFFFF_FFFF, 1'b0);
        push_req(32'h7FFF_FFFF, 1'b1);
        push_req(32'h0000_0000, 1'b0);
        push_req(32'h8000_0000, 1'b1);
        push_req(32'hFFFF_FFFF, 1'b1);
        push_req(32'h0000_0003, 1'b1);
        push_req(32'h0000_0005, 1'b1);
        // zero delta never stable
        set_window(7'd2);
        write_reg(CFG_STABLE_DELTA, 32'd0);
        push_req(32'd5, 1'b1);
        push_req(32'd5, 1'b1);
        write_reg(CFG_STABLE_DELTA, 32'd1);
        push_req(32'd5, 1'b1);
        push_req(32'd6, 1'b1);
        // widest delta against the widest range
        write_reg(CFG_STABLE_DELTA, 32'hFFFF_FFFF);
        push_req(32'h8000_0000, 1'b1);
        push_req(32'h7FFF_FFFF, 1'b1);
        push_req(32'h7FFF_FFFE, 1'b1);
        // length below minimum acts as two
        set_window(7'd0);
        push_req(32'd100, 1'b1);
        push_req(32'd200, 1'b1);
        push_req(32'd150, 1'b1);
        // length above max, then shrink and regrow
        set_window(7'd127);
        for (k = 0; k < 6; k++)
            push_req(32'd1000 + k * 7, 1'b1);
        set_window(7'd3);
        push_req(32'd5000, 1'b1);
        set_window(7'd64);
        push_req(32'd5001, 1'b1);

        // random phases
        run_phase(7'd8, 32'd10, 16, 0, 0, 80, 1'b1);
        run_phase(7'd2, 32'd0, 4, 48, 0, 60, 1'b0);
        run_phase(7'd64, 32'd1000, 1500, 0, 48, 90, 1'b0);
        run_phase(7'd3, 32'hFFFF_FFFF, 1000, 9, 9, 80, 1'b0);
        run_phase(7'd0, 32'd5, 8, 48, 0, 60, 1'b0);
        run_phase(7'd127, 32'd200, 300, 0, 48, 60, 1'b0);
        run_phase(7'd65, 32'd50, 64, 9, 9, 60, 1'b0);
        rnd_delta = $urandom_range(500);
        run_phase(WLEN_W'($urandom_range(2, 64)), rnd_delta, 2 * rnd_delta + 1, 0, 0, 60, 1'b1);
        run_phase(7'd1, 32'd1, 2, 9, 9, 60, 1'b0);
        run_phase(WLEN_W'($urandom_range(127)), $urandom, $urandom_range(1 << 20), 48, 0, 90,
                  1'b0);

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("covered %0d requests (%0d invalid) across %0d register writes",
                 req_count, invalid_count, reg_writes);
        $display("checked %0d results, %0d of them stable", results_seen, stable_seen);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
